@@ rtl/core/utft_pkg.sv @@
// ----------------------------------------------------------------------------
// utft_pkg
// Shared types, codes and helpers of the UTF transcoder.
// ----------------------------------------------------------------------------
package utft_pkg;

  // Encoding formats; code three is handled as UTF-32
  localparam logic [1:0] FMT_UTF8  = 2'd0;
  localparam logic [1:0] FMT_UTF16 = 2'd1;
  localparam logic [1:0] FMT_UTF32 = 2'd2;

  // Error codes of a result
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_INVALID_LEAD = 2'd1;
  localparam logic [1:0] ERR_RANGE        = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FORMAT = 1'd1;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned UNIT_W    = 32;
  localparam int unsigned MAX_UNITS = 4;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              block_start;
  } in_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] out_unit;
    logic              last_unit;
    logic [1:0]        error_code;
  } out_item_t;

  // Decoder state carried from one unit to the next
  typedef struct packed {
    logic [CP_W-1:0] partial_point;
    logic [1:0]      units_remaining;
    logic [1:0]      block_byte_pos;
  } dec_state_t;

  // Outcome of decoding one unit
  typedef struct packed {
    logic            produce;     // at least one result follows
    logic [1:0]      error_code;
    logic [CP_W-1:0] code_point;
    dec_state_t      next_state;
  } dec_step_t;

  // One to four target units that belong together
  typedef struct packed {
    logic [MAX_UNITS-1:0][CP_W-1:0] units;
    logic [1:0]                     last_idx;
    logic [1:0]                     error_code;
  } unit_bundle_t;

  // Block position, saturating at three
  function automatic logic [1:0] pos_advance(input logic [1:0] pos, input logic [1:0] step);
    logic [2:0] sum;
    sum = {1'b0, pos} + {1'b0, step};
    return sum[2] ? 2'd3 : sum[1:0];
  endfunction

endpackage

@@ rtl/core/utf_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf_transcoder
// Streaming converter between UTF-8, UTF-16 and UTF-32 code units.
// ----------------------------------------------------------------------------
// The block takes one source code unit per transfer on the item channel and
// gives target code units on the result channel, one unit per transfer, with
// last_unit set on the final unit of each code point and on every error.
// It accepts a new unit every cycle unless item_stall is high; a unit whose
// code point is complete produces one to four results, and the result port
// sends one of them per cycle while result_stall is low, so sustained
// throughput is one input per cycle while each unit yields at most one result
// and the output is not stalled, and otherwise is set by the result count.
// A unit passes an input register, then the decode/encode logic feeding the
// output bundle register. Units that only open or extend a sequence, and
// stray leads inside the block-start window, produce nothing and pass through
// even while the output is busy. Configuration (source_format, target_format)
// is written through cfg_write, cfg_index and cfg_data; the user must write it
// only while the block is idle, which the block does not enforce. Writing
// source_format abandons any open sequence. Format code three behaves as UTF-32.
// ----------------------------------------------------------------------------
module utf_transcoder (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_write,
  input  logic [utft_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [1:0]                          cfg_data,

  input  logic                                item_valid,
  output logic                                item_stall,
  input  utft_pkg::in_item_t                  item,

  output logic                                result_valid,
  input  logic                                result_stall,
  output utft_pkg::out_item_t                 result
);

  // configuration
  logic [1:0] source_format;
  logic [1:0] target_format;

  // input register
  logic               in_full;
  utft_pkg::in_item_t in_item;

  // decoder state
  utft_pkg::dec_state_t state;

  utft_pkg::dec_step_t    step;
  utft_pkg::unit_bundle_t bundle;
  logic                   load_ready;
  logic                   advance;   // held unit leaves the input register
  logic                   load;      // ... and carries results into the queue
  logic                   item_take;

  utft_decoder u_decoder (
    .source_format (source_format),
    .item          (in_item),
    .state         (state),
    .step          (step)
  );

  utft_encoder u_encoder (
    .target_format (target_format),
    .code_point    (step.code_point),
    .error_code    (step.error_code),
    .bundle        (bundle)
  );

  // results-free units never wait on the output side
  assign advance = in_full && (load_ready || !step.produce);
  assign load = advance && step.produce;
  assign item_stall = in_full && !advance;
  assign item_take = item_valid && !item_stall;

  utft_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .bundle_in    (bundle),
    .load_ready   (load_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      in_item <= item;
    end
  end

  // config and state; the user must write only while idle, which is not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= utft_pkg::FMT_UTF8;
      target_format <= utft_pkg::FMT_UTF16;
      state <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        utft_pkg::REG_SOURCE_FORMAT: begin
          source_format <= cfg_data;
          state.partial_point <= '0;
          state.units_remaining <= 2'd0;
        end
        utft_pkg::REG_TARGET_FORMAT: begin
          target_format <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      state <= step.next_state;
    end
  end

  // UTF-32 input never leaves a sequence open
  assert property (@(posedge clk) disable iff (rst)
    (state.units_remaining != 2'd0) |->
      (source_format == utft_pkg::FMT_UTF8 || source_format == utft_pkg::FMT_UTF16))
    else $error("open sequence with UTF-32 source");

  // UTF-16 input waits for at most one low surrogate
  assert property (@(posedge clk) disable iff (rst)
    (source_format == utft_pkg::FMT_UTF16) |-> (state.units_remaining <= 2'd1))
    else $error("UTF-16 sequence longer than a pair");

  // a held unit is never replaced before it has been consumed
  assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_item)))
    else $error("input register lost a unit");

endmodule

@@ rtl/core/utft_decoder.sv @@
// ----------------------------------------------------------------------------
// utft_decoder
// Folds one source unit into the decoder state; flags a finished code point
// or an error.
// ----------------------------------------------------------------------------
module utft_decoder (
  input  logic [1:0]           source_format,
  input  utft_pkg::in_item_t   item,
  input  utft_pkg::dec_state_t state,
  output utft_pkg::dec_step_t  step
);

  utft_pkg::dec_state_t st0;
  logic [7:0]  b;
  logic [15:0] w;
  logic [1:0]  rem_dec;

  always_comb begin
    // block start clears position and abandons an open sequence
    st0 = item.block_start ? '0 : state;
    b = item.code_unit[7:0];
    w = item.code_unit[15:0];
    rem_dec = st0.units_remaining - 2'd1;

    step.produce = 1'b0;
    step.error_code = utft_pkg::ERR_NONE;
    step.code_point = '0;
    step.next_state = st0;

    case (source_format)
      utft_pkg::FMT_UTF8: begin
        if (st0.units_remaining != 2'd0) begin
          step.next_state.partial_point = {st0.partial_point[14:0], b[5:0]};
          step.next_state.units_remaining = rem_dec;
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
          step.code_point = {st0.partial_point[14:0], b[5:0]};
          step.produce = (rem_dec == 2'd0);
        end else if (!b[7]) begin
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
          step.code_point = {13'd0, b};
          step.produce = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          step.next_state.partial_point = {16'd0, b[4:0]};
          step.next_state.units_remaining = 2'd1;
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
        end else if (b[7:4] == 4'b1110) begin
          step.next_state.partial_point = {17'd0, b[3:0]};
          step.next_state.units_remaining = 2'd2;
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
        end else if (b[7:3] == 5'b11110) begin
          step.next_state.partial_point = {18'd0, b[2:0]};
          step.next_state.units_remaining = 2'd3;
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
        end else begin
          // stray continuation or 11111xxx: skipped near block start
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
          step.produce = (st0.block_byte_pos >= 2'd3);
          step.error_code = utft_pkg::ERR_INVALID_LEAD;
        end
      end
      utft_pkg::FMT_UTF16: begin
        if (st0.units_remaining != 2'd0) begin
          step.code_point = {1'b0, st0.partial_point[9:0], w[9:0]} + 21'h01_0000;
          step.produce = 1'b1;
          step.next_state.partial_point = '0;
          step.next_state.units_remaining = 2'd0;
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd2);
        end else if (w[15:10] == 6'b110110) begin
          step.next_state.partial_point = {11'd0, w[9:0]};
          step.next_state.units_remaining = 2'd1;
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd2);
        end else if (w[15:10] == 6'b110111) begin
          // lone low surrogate
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd1);
          step.produce = (st0.block_byte_pos >= 2'd2);
          step.error_code = utft_pkg::ERR_INVALID_LEAD;
        end else begin
          step.next_state.block_byte_pos = utft_pkg::pos_advance(st0.block_byte_pos, 2'd2);
          step.code_point = {5'd0, w};
          step.produce = 1'b1;
        end
      end
      default: begin
        step.next_state.units_remaining = 2'd0;
        step.produce = 1'b1;
        step.code_point = item.code_unit[20:0];
        if (item.code_unit >= 32'h0011_0000) begin
          step.error_code = utft_pkg::ERR_RANGE;
        end
      end
    endcase
  end

endmodule

@@ rtl/core/utft_encoder.sv @@
// ----------------------------------------------------------------------------
// utft_encoder
// Turns a code point, or an error, into the bundle of target units.
// ----------------------------------------------------------------------------
module utft_encoder (
  input  logic [1:0]              target_format,
  input  logic [20:0]             code_point,
  input  logic [1:0]              error_code,
  output utft_pkg::unit_bundle_t  bundle
);

  logic [20:0] cp;
  logic [20:0] v;

  always_comb begin
    cp = code_point;
    v = cp - 21'h01_0000;
    bundle.units = '0;
    bundle.last_idx = 2'd0;
    bundle.error_code = error_code;

    if (error_code != utft_pkg::ERR_NONE) begin
      bundle.units = '0;
    end else begin
      case (target_format)
        utft_pkg::FMT_UTF8: begin
          if (cp < 21'h80) begin
            bundle.units[0] = cp;
          end else if (cp < 21'h800) begin
            bundle.units[0] = {13'd0, 3'b110, cp[10:6]};
            bundle.units[1] = {13'd0, 2'b10, cp[5:0]};
            bundle.last_idx = 2'd1;
          end else if (cp < 21'h01_0000) begin
            bundle.units[0] = {13'd0, 4'b1110, cp[15:12]};
            bundle.units[1] = {13'd0, 2'b10, cp[11:6]};
            bundle.units[2] = {13'd0, 2'b10, cp[5:0]};
            bundle.last_idx = 2'd2;
          end else begin
            bundle.units[0] = {13'd0, 5'b11110, cp[20:18]};
            bundle.units[1] = {13'd0, 2'b10, cp[17:12]};
            bundle.units[2] = {13'd0, 2'b10, cp[11:6]};
            bundle.units[3] = {13'd0, 2'b10, cp[5:0]};
            bundle.last_idx = 2'd3;
          end
        end
        utft_pkg::FMT_UTF16: begin
          if (cp > 21'h00_FFFF) begin
            bundle.units[0] = {5'd0, 6'b110110, v[19:10]};
            bundle.units[1] = {5'd0, 6'b110111, v[9:0]};
            bundle.last_idx = 2'd1;
          end else begin
            bundle.units[0] = cp;
          end
        end
        default: begin
          bundle.units[0] = cp;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/utft_out_queue.sv @@
// ----------------------------------------------------------------------------
// utft_out_queue
// Holds one bundle of target units and hands them out one per transfer.
// ----------------------------------------------------------------------------
module utft_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  utft_pkg::unit_bundle_t bundle_in,
  output logic                   load_ready,
  output logic                   result_valid,
  input  logic                   result_stall,
  output utft_pkg::out_item_t    result
);

  utft_pkg::unit_bundle_t bundle;
  logic                   full;
  logic [1:0]             idx;
  logic                   take;
  logic                   at_last;

  assign take = full && !result_stall;
  assign at_last = (idx == bundle.last_idx);
  assign load_ready = !full || (take && at_last);

  assign result_valid = full;
  assign result.out_unit = {11'd0, bundle.units[idx]};
  assign result.last_unit = at_last;
  assign result.error_code = bundle.error_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        full <= 1'b0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= bundle_in;
    end
  end

  // a bundle not yet finished stays on the port after a transfer
  assert property (@(posedge clk) disable iff (rst)
    (take && !at_last) |=> (result_valid && idx == $past(idx) + 2'd1))
    else $error("bundle dropped before its last unit");

  // error results are always single units
  assert property (@(posedge clk) disable iff (rst)
    (full && bundle.error_code != utft_pkg::ERR_NONE) |-> (bundle.last_idx == 2'd0))
    else $error("error result spans more than one unit");

  // a new bundle never overwrites one still being sent
  assert property (@(posedge clk) disable iff (rst)
    load |-> load_ready)
    else $error("bundle loaded while output busy");

endmodule
